/* hdl/gfs_pkg.sv */
// shared types and constants of the greedy feature gate selector
`default_nettype none

package gfs_pkg;

  localparam int FEATURES = 1024;
  localparam int FEAT_W   = $clog2(FEATURES);
  localparam int CNT_W    = FEAT_W + 1;
  localparam int SUM_W    = 48;
  localparam int MAG_W    = 31;
  localparam int PROD_W   = 32;
  localparam int MEM_W    = 2;

  localparam logic ACT_GATE  = 1'b0;
  localparam logic ACT_SCORE = 1'b1;

  typedef enum logic [1:0] {
    REG_OFF_GAIN    = 2'd0,
    REG_PASSES      = 2'd1,
    REG_MAX_ROUNDS  = 2'd2,
    REG_RANDOM_MODE = 2'd3
  } gfs_reg_t;

  typedef struct packed {
    logic signed [15:0] off_gain;
    logic [15:0]        passes_per_round;
    logic [CNT_W-1:0]   max_rounds;
    logic               random_mode;
  } gfs_cfg_t;

  typedef struct packed {
    logic               action;
    logic [FEAT_W-1:0]  feature_index;
    logic signed [15:0] sample_value;
    logic signed [15:0] grad_value;
    logic               feature_end;
    logic               pass_end;
  } gfs_item_t;

  typedef struct packed {
    logic               action;
    logic [FEAT_W-1:0]  feature_index;
    logic signed [15:0] sample_value;
    logic               feature_end;
    logic               pass_end;
    logic [PROD_W-1:0]  gate_prod;
    logic [MAG_W-1:0]   mag;
  } gfs_prod_t;

  // mask store word: {generation, selected}
  typedef struct packed {
    logic              we;
    logic [FEAT_W-1:0] addr;
    logic [MEM_W-1:0]  data;
  } gfs_wr_t;

endpackage

`default_nettype wire

/* hdl/gfs_ram.sv */
// single-port-write, registered-read memory for the selection mask
`default_nettype none

module gfs_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 2
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* hdl/gfs_front.sv */
// input register and multiplier stage
`default_nettype none

module gfs_front import gfs_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      advance,
  input  wire logic      in_take,
  input  wire gfs_item_t in_item,
  input  wire gfs_cfg_t  cfg,
  output logic [FEAT_W-1:0] s1_index,
  output logic           s2_valid,
  output gfs_prod_t      s2_item
);

  logic      s1_valid_r;
  gfs_item_t s1_r;
  logic      s2_valid_r;
  gfs_prod_t s2_r;

  logic signed [PROD_W-1:0] gate_prod;
  logic signed [PROD_W-1:0] score_prod;
  logic [PROD_W-1:0]        score_abs;
  gfs_prod_t                s2_nxt;

  always_comb begin
    gate_prod  = s1_r.sample_value * cfg.off_gain;
    score_prod = s1_r.sample_value * s1_r.grad_value;
    score_abs  = score_prod[PROD_W-1] ? PROD_W'(-score_prod) : PROD_W'(score_prod);
    s2_nxt.action        = s1_r.action;
    s2_nxt.feature_index = s1_r.feature_index;
    s2_nxt.sample_value  = s1_r.sample_value;
    s2_nxt.feature_end   = s1_r.feature_end;
    s2_nxt.pass_end      = s1_r.pass_end;
    s2_nxt.gate_prod     = gate_prod;
    // |product| is at most 2^30
    s2_nxt.mag           = score_abs[MAG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r <= in_take;
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_r <= in_item;
      s2_r <= s2_nxt;
    end
  end

  assign s1_index = s1_r.feature_index;
  assign s2_valid = s2_valid_r;
  assign s2_item  = s2_r;

endmodule

`default_nettype wire

/* hdl/gfs_sel.sv */
// selection state, gating saturation and result register
`default_nettype none

module gfs_sel import gfs_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             advance,
  input  wire logic             s2_valid,
  input  wire gfs_prod_t        s2_item,
  input  wire logic [MEM_W-1:0] mem_rdata,
  input  wire logic             fwd_hit,
  input  wire gfs_cfg_t         cfg,
  output gfs_wr_t               mask_wr,
  output logic                  out_valid,
  output logic signed [15:0]    out_gated_value,
  output logic                  out_feature_active,
  output logic                  out_added_valid,
  output logic [FEAT_W-1:0]     out_added_index,
  output logic [CNT_W-1:0]      out_active_count
);

  logic [31:0]       pass_cnt_r,    pass_cnt_nxt;
  logic [15:0]       round_phase_r, round_phase_nxt;
  logic [CNT_W-1:0]  greedy_cnt_r,  greedy_cnt_nxt;
  logic [SUM_W-1:0]  fsum_r,        fsum_nxt;
  logic [SUM_W-1:0]  best_sum_r,    best_sum_nxt;
  logic [FEAT_W-1:0] best_idx_r,    best_idx_nxt;
  logic              best_found_r,  best_found_nxt;
  logic              rand_done_r,   rand_done_nxt;
  logic              rand_on_r,     rand_on_nxt;
  logic [CNT_W-1:0]  rand_lim_r,    rand_lim_nxt;
  logic              gen_r,         gen_nxt;

  logic              out_valid_r;
  logic signed [15:0] gated_r;
  logic              active_r;
  logic              added_r;
  logic [FEAT_W-1:0] added_idx_r;
  logic [CNT_W-1:0]  count_r;

  logic              active;
  logic [CNT_W-1:0]  limit;
  logic              eligible;
  logic [SUM_W:0]    sum_wide;
  logic [SUM_W-1:0]  sum_sat;
  logic signed [PROD_W:0] rnd;
  logic signed [PROD_W:0] shifted;
  logic signed [15:0] gate_sat;
  logic signed [15:0] gated;
  logic              added;
  logic [FEAT_W-1:0] added_idx;
  logic [15:0]       ppr;
  logic [16:0]       phase_inc;
  logic              work;

  always_comb begin
    active = fwd_hit || (mem_rdata[0] && (mem_rdata[1] == gen_r)) ||
             (rand_on_r && ({1'b0, s2_item.feature_index} < rand_lim_r));
    limit    = (cfg.max_rounds < CNT_W'(FEATURES)) ? cfg.max_rounds : CNT_W'(FEATURES);
    eligible = (round_phase_r == 16'd0) && !cfg.random_mode && (greedy_cnt_r < limit);

    // round half up, floor shift, then clamp to 16 bits
    rnd     = $signed({s2_item.gate_prod[PROD_W-1], s2_item.gate_prod}) + 33'sd2048;
    shifted = rnd >>> 12;
    if ((&shifted[PROD_W:15]) || !(|shifted[PROD_W:15])) begin
      gate_sat = shifted[15:0];
    end else if (shifted[PROD_W]) begin
      gate_sat = -16'sd32768;
    end else begin
      gate_sat = 16'sd32767;
    end

    sum_wide = {1'b0, fsum_r} + {{(SUM_W + 1 - MAG_W){1'b0}}, s2_item.mag};
    sum_sat  = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];

    ppr       = (cfg.passes_per_round == 16'd0) ? 16'd1 : cfg.passes_per_round;
    phase_inc = {1'b0, round_phase_r} + 17'd1;

    pass_cnt_nxt    = pass_cnt_r;
    round_phase_nxt = round_phase_r;
    greedy_cnt_nxt  = greedy_cnt_r;
    fsum_nxt        = fsum_r;
    best_sum_nxt    = best_sum_r;
    best_idx_nxt    = best_idx_r;
    best_found_nxt  = best_found_r;
    rand_done_nxt   = rand_done_r;
    rand_on_nxt     = rand_on_r;
    rand_lim_nxt    = rand_lim_r;
    gen_nxt         = gen_r;
    mask_wr         = '0;
    gated           = 16'sd0;
    added           = 1'b0;
    added_idx       = '0;
    work            = s2_valid && advance;

    if (work) begin
      if (s2_item.action == ACT_GATE) begin
        gated = active ? s2_item.sample_value : gate_sat;
      end else begin
        fsum_nxt = sum_sat;
        if (s2_item.feature_end) begin
          if (eligible && !active && (!best_found_r || (sum_sat > best_sum_r))) begin
            best_found_nxt = 1'b1;
            best_sum_nxt   = sum_sat;
            best_idx_nxt   = s2_item.feature_index;
          end
          fsum_nxt = '0;
        end
        if (s2_item.pass_end) begin
          if (eligible && best_found_nxt) begin
            mask_wr.we     = 1'b1;
            mask_wr.addr   = best_idx_nxt;
            mask_wr.data   = {gen_r, 1'b1};
            greedy_cnt_nxt = greedy_cnt_r + CNT_W'(1);
            added          = 1'b1;
            added_idx      = best_idx_nxt;
          end
          // random selection: a prefix range, older greedy bits go stale
          if (cfg.random_mode && !rand_done_r && (pass_cnt_r == 32'd0)) begin
            rand_on_nxt   = 1'b1;
            rand_lim_nxt  = limit;
            rand_done_nxt = 1'b1;
            gen_nxt       = ~gen_r;
          end
          best_found_nxt = 1'b0;
          best_sum_nxt   = '0;
          fsum_nxt       = '0;
          if (pass_cnt_r != 32'hFFFF_FFFF) begin
            pass_cnt_nxt = pass_cnt_r + 32'd1;
          end
          round_phase_nxt = (phase_inc >= {1'b0, ppr}) ? 16'd0 : phase_inc[15:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pass_cnt_r    <= '0;
      round_phase_r <= '0;
      greedy_cnt_r  <= '0;
      fsum_r        <= '0;
      best_sum_r    <= '0;
      best_idx_r    <= '0;
      best_found_r  <= 1'b0;
      rand_done_r   <= 1'b0;
      rand_on_r     <= 1'b0;
      rand_lim_r    <= '0;
      gen_r         <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      pass_cnt_r    <= pass_cnt_nxt;
      round_phase_r <= round_phase_nxt;
      greedy_cnt_r  <= greedy_cnt_nxt;
      fsum_r        <= fsum_nxt;
      best_sum_r    <= best_sum_nxt;
      best_idx_r    <= best_idx_nxt;
      best_found_r  <= best_found_nxt;
      rand_done_r   <= rand_done_nxt;
      rand_on_r     <= rand_on_nxt;
      rand_lim_r    <= rand_lim_nxt;
      gen_r         <= gen_nxt;
      if (advance) begin
        out_valid_r <= s2_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      gated_r     <= gated;
      active_r    <= active;
      added_r     <= added;
      added_idx_r <= added_idx;
      count_r     <= greedy_cnt_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_gated_value    = gated_r;
  assign out_feature_active = active_r;
  assign out_added_valid    = added_r;
  assign out_added_index    = added_idx_r;
  assign out_active_count   = count_r;

endmodule

`default_nettype wire

/* hdl/greedy_feature_gate_selector_unit.sv */
// top level of the greedy feature gate selector
`default_nettype none

// channel | direction | handshake          | payload
// cfg     | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
// in      | in        | in_valid/in_ready   | action, feature index, sample, grad, ends
// out     | out       | out_valid/out_ready | gated value, active, added, count
//
// one item per cycle while out_ready and the clearing pass allow; each item passes
// the input register, multiplier register and result register, mask read in between.
// after reset a clearing pass writes all 1024 mask entries, in_ready low.
// a stalled result holds the whole pipeline; cfg_ready is always high.

module greedy_feature_gate_selector_unit import gfs_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [15:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_action,
  input  wire logic [FEAT_W-1:0]  in_feature_index,
  input  wire logic signed [15:0] in_sample_value,
  input  wire logic signed [15:0] in_grad_value,
  input  wire logic               in_feature_end,
  input  wire logic               in_pass_end,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [15:0]      out_gated_value,
  output logic                    out_feature_active,
  output logic                    out_added_valid,
  output logic [FEAT_W-1:0]       out_added_index,
  output logic [CNT_W-1:0]        out_active_count
);

  gfs_cfg_t          cfg_r;
  logic              clr_busy_r;
  logic [FEAT_W-1:0] clr_addr_r;
  logic              fwd_r;

  logic              advance;
  logic              in_take;
  gfs_item_t         in_item;
  logic [FEAT_W-1:0] s1_index;
  logic              s2_valid;
  gfs_prod_t         s2_item;
  logic [MEM_W-1:0]  mem_rdata;
  gfs_wr_t           core_wr;
  logic              ram_we;
  logic [FEAT_W-1:0] ram_waddr;
  logic [MEM_W-1:0]  ram_wdata;

  assign cfg_ready = 1'b1;
  assign advance   = !out_valid || out_ready;
  assign in_ready  = advance && !clr_busy_r;
  assign in_take   = in_valid && in_ready;

  always_comb begin
    in_item.action        = in_action;
    in_item.feature_index = in_feature_index;
    in_item.sample_value  = in_sample_value;
    in_item.grad_value    = in_grad_value;
    in_item.feature_end   = in_feature_end;
    in_item.pass_end      = in_pass_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.off_gain         <= 16'sd0;
      cfg_r.passes_per_round <= 16'd1;
      cfg_r.max_rounds       <= '0;
      cfg_r.random_mode      <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (gfs_reg_t'(cfg_index))
        REG_OFF_GAIN:    cfg_r.off_gain         <= cfg_data;
        REG_PASSES:      cfg_r.passes_per_round <= cfg_data;
        REG_MAX_ROUNDS:  cfg_r.max_rounds       <= cfg_data[CNT_W-1:0];
        REG_RANDOM_MODE: cfg_r.random_mode      <= cfg_data[0];
      endcase
    end
  end

  // clearing pass over the mask memory
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + FEAT_W'(1);
      if (clr_addr_r == FEAT_W'(FEATURES - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // the write issued while an item reads the memory is not yet visible to it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else if (advance) begin
      fwd_r <= core_wr.we && (core_wr.addr == s1_index);
    end
  end

  assign ram_we    = clr_busy_r || core_wr.we;
  assign ram_waddr = clr_busy_r ? clr_addr_r : core_wr.addr;
  assign ram_wdata = clr_busy_r ? '0 : core_wr.data;

  gfs_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .advance  (advance),
    .in_take  (in_take),
    .in_item  (in_item),
    .cfg      (cfg_r),
    .s1_index (s1_index),
    .s2_valid (s2_valid),
    .s2_item  (s2_item)
  );

  gfs_ram #(
    .DEPTH (FEATURES),
    .WIDTH (MEM_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (advance),
    .raddr (s1_index),
    .rdata (mem_rdata)
  );

  gfs_sel u_sel (
    .clk                (clk),
    .rst_n              (rst_n),
    .advance            (advance),
    .s2_valid           (s2_valid),
    .s2_item            (s2_item),
    .mem_rdata          (mem_rdata),
    .fwd_hit            (fwd_r),
    .cfg                (cfg_r),
    .mask_wr            (core_wr),
    .out_valid          (out_valid),
    .out_gated_value    (out_gated_value),
    .out_feature_active (out_feature_active),
    .out_added_valid    (out_added_valid),
    .out_added_index    (out_added_index),
    .out_active_count   (out_active_count)
  );

  a_clear_once: assert property (@(posedge clk) disable iff (!rst_n)
    !clr_busy_r |=> !clr_busy_r)
    else $error("clearing pass restarted");

  a_no_add_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !core_wr.we)
    else $error("mask write during clearing pass");

  a_add_reported: assert property (@(posedge clk) disable iff (!rst_n)
    core_wr.we |=> out_valid && out_added_valid)
    else $error("feature added without a reporting result");

  a_add_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_added_valid |-> out_active_count != '0)
    else $error("added feature with zero count");

  a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready ##1 out_valid |-> out_active_count >= $past(out_active_count))
    else $error("active count went down");

endmodule

`default_nettype wire
